@@ rtl/dle_rx_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// DLE receiver package
// Shared types, character codes and status codes for the DLE/STX/ETX
// byte-stuffed frame receiver.
// ----------------------------------------------------------------------------
package dle_rx_pkg;

    localparam int LENGTH_BITS = 16;
    localparam int FLUSH_LIMIT = 16384;
    localparam int FLUSH_W     = $clog2(FLUSH_LIMIT + 1);

    localparam logic [7:0] CH_DLE = 8'h10;
    localparam logic [7:0] CH_STX = 8'h02;
    localparam logic [7:0] CH_ETX = 8'h03;
    localparam logic [7:0] CH_ACK = 8'h06;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_TIMEOUT = 2'd1;
    localparam logic [1:0] ST_ERROR   = 2'd2;

    localparam logic [1:0] REG_EOS_ENABLE   = 2'd0;
    localparam logic [1:0] REG_EOS_CHAR     = 2'd1;
    localparam logic [1:0] REG_EOS_ALL_BITS = 2'd2;

    localparam logic KIND_START = 1'b0;

    typedef struct packed {
        logic                   kind;
        logic [7:0]             rx_byte;
        logic [LENGTH_BITS-1:0] max_length;
    } t_in_item;

    typedef struct packed {
        logic                   data_valid;
        logic [7:0]             data_byte;
        logic                   done_res;
        logic [1:0]             status;
        logic                   end_seen;
        logic [LENGTH_BITS-1:0] byte_count;
    } t_out_item;

    typedef struct packed {
        logic       eos_enable;
        logic [7:0] eos_char;
        logic       eos_all_bits;
    } t_cfg;

endpackage

@@ rtl/dle_rx_fsm.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// DLE receiver frame state machine
// Holds the per-read state and turns one transaction into at most one
// result: unstuffing, end-of-string detection, overflow and flush.
// ----------------------------------------------------------------------------
module dle_rx_fsm
    import dle_rx_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_cfg      i_cfg,
    input  logic      i_step,
    input  t_in_item  i_item,
    output logic      o_emit,
    output t_out_item o_res
);

    localparam logic [3:0] PH_IDLE     = 4'd0;
    localparam logic [3:0] PH_ONE_A    = 4'd1;
    localparam logic [3:0] PH_ONE_B    = 4'd2;
    localparam logic [3:0] PH_HDR_DLE  = 4'd3;
    localparam logic [3:0] PH_HDR_STX  = 4'd4;
    localparam logic [3:0] PH_DATA     = 4'd5;
    localparam logic [3:0] PH_DATA_ESC = 4'd6;
    localparam logic [3:0] PH_WAIT_ACK = 4'd7;
    localparam logic [3:0] PH_FL_IDLE  = 4'd8;
    localparam logic [3:0] PH_FL_ESC   = 4'd9;
    localparam logic [3:0] PH_FL_ACK   = 4'd10;

    logic [3:0]             r_phase,    n_phase;
    logic [LENGTH_BITS-1:0] r_stored,   n_stored;
    logic [LENGTH_BITS-1:0] r_capacity, n_capacity;
    logic [FLUSH_W-1:0]     r_flush,    n_flush;
    logic                   r_end,      n_end;
    logic [7:0]             r_held,     n_held;

    logic [7:0]             c;
    logic [7:0]             eos_mask;
    logic                   eos_hit;
    logic                   full;
    logic [LENGTH_BITS-1:0] stored_inc;
    logic [FLUSH_W-1:0]     flush_inc;
    logic                   flush_over;
    logic                   flush_inc_over;

    assign c              = i_item.rx_byte;
    assign eos_mask       = i_cfg.eos_all_bits ? 8'hFF : 8'h7F;
    assign eos_hit        = i_cfg.eos_enable && (((c ^ i_cfg.eos_char) & eos_mask) == 8'h00);
    assign full           = (r_stored == r_capacity);
    assign stored_inc     = r_stored + LENGTH_BITS'(1);
    assign flush_inc      = r_flush + FLUSH_W'(1);
    assign flush_over     = (r_flush >= FLUSH_W'(FLUSH_LIMIT));
    assign flush_inc_over = (flush_inc >= FLUSH_W'(FLUSH_LIMIT));

    always_comb begin
        n_phase    = r_phase;
        n_stored   = r_stored;
        n_capacity = r_capacity;
        n_flush    = r_flush;
        n_end      = r_end;
        n_held     = r_held;
        o_emit     = 1'b0;
        o_res      = '0;

        if (i_item.kind == KIND_START) begin
            n_capacity = i_item.max_length;
            n_stored   = '0;
            n_flush    = '0;
            n_end      = 1'b0;
            n_held     = '0;
            n_phase    = (i_item.max_length == LENGTH_BITS'(1)) ? PH_ONE_A : PH_HDR_DLE;
        end else begin
            case (r_phase)
                PH_ONE_A: begin
                    n_held  = c;
                    n_phase = PH_ONE_B;
                end
                PH_ONE_B: begin
                    o_emit         = 1'b1;
                    o_res.done_res = 1'b1;
                    n_phase        = PH_IDLE;
                    if (c == CH_ACK) begin
                        n_stored         = LENGTH_BITS'(1);
                        o_res.data_valid = 1'b1;
                        o_res.data_byte  = r_held;
                        o_res.status     = ST_OK;
                        o_res.byte_count = LENGTH_BITS'(1);
                    end else begin
                        o_res.status = ST_TIMEOUT;
                    end
                end
                PH_HDR_DLE, PH_HDR_STX: begin
                    if (c != ((r_phase == PH_HDR_DLE) ? CH_DLE : CH_STX)) begin
                        o_emit         = 1'b1;
                        o_res.done_res = 1'b1;
                        o_res.status   = ST_ERROR;
                        n_phase        = PH_IDLE;
                    end else begin
                        n_phase = (r_phase == PH_HDR_DLE) ? PH_HDR_STX : PH_DATA;
                    end
                end
                PH_DATA, PH_DATA_ESC: begin
                    if ((r_phase == PH_DATA) && (c == CH_DLE)) begin
                        n_phase = PH_DATA_ESC;
                    end else if ((r_phase == PH_DATA) || (c == CH_DLE)) begin
                        // payload byte
                        if (full) begin
                            n_phase = PH_FL_IDLE;
                            n_flush = '0;
                        end else begin
                            n_stored         = stored_inc;
                            o_emit           = 1'b1;
                            o_res.data_valid = 1'b1;
                            o_res.data_byte  = c;
                            o_res.byte_count = stored_inc;
                            o_res.end_seen   = r_end | eos_hit;
                            if (eos_hit) begin
                                n_end   = 1'b1;
                                n_phase = PH_FL_IDLE;
                                n_flush = '0;
                            end else begin
                                n_phase = PH_DATA;
                            end
                        end
                    end else if (c == CH_ETX) begin
                        n_phase = PH_WAIT_ACK;
                    end else begin
                        o_emit           = 1'b1;
                        o_res.done_res   = 1'b1;
                        o_res.status     = ST_ERROR;
                        o_res.byte_count = r_stored;
                        n_phase          = PH_IDLE;
                    end
                end
                PH_WAIT_ACK: begin
                    o_emit           = 1'b1;
                    o_res.done_res   = 1'b1;
                    o_res.byte_count = r_stored;
                    n_phase          = PH_IDLE;
                    if (c == CH_ACK) begin
                        n_end          = 1'b1;
                        o_res.status   = ST_OK;
                        o_res.end_seen = 1'b1;
                    end else begin
                        o_res.status = ST_TIMEOUT;
                    end
                end
                PH_FL_IDLE: begin
                    n_flush = flush_inc;
                    if (c == CH_DLE) begin
                        n_phase = PH_FL_ESC;
                    end else begin
                        n_phase = PH_FL_IDLE;
                        if (flush_inc_over) begin
                            o_emit           = 1'b1;
                            o_res.done_res   = 1'b1;
                            o_res.status     = ST_ERROR;
                            o_res.end_seen   = r_end;
                            o_res.byte_count = r_stored;
                            n_phase          = PH_IDLE;
                        end
                    end
                end
                PH_FL_ESC: begin
                    if (c == CH_ETX) begin
                        n_phase = PH_FL_ACK;
                    end else begin
                        n_phase = PH_FL_IDLE;
                        if (flush_over) begin
                            o_emit           = 1'b1;
                            o_res.done_res   = 1'b1;
                            o_res.status     = ST_ERROR;
                            o_res.end_seen   = r_end;
                            o_res.byte_count = r_stored;
                            n_phase          = PH_IDLE;
                        end
                    end
                end
                PH_FL_ACK: begin
                    o_emit           = 1'b1;
                    o_res.done_res   = 1'b1;
                    o_res.status     = (c == CH_ACK) ? ST_OK : ST_ERROR;
                    o_res.end_seen   = r_end;
                    o_res.byte_count = r_stored;
                    n_phase          = PH_IDLE;
                end
                default: begin
                    n_phase = PH_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase    <= PH_IDLE;
            r_stored   <= '0;
            r_capacity <= '0;
            r_flush    <= '0;
            r_end      <= 1'b0;
            r_held     <= '0;
        end else if (i_step) begin
            r_phase    <= n_phase;
            r_stored   <= n_stored;
            r_capacity <= n_capacity;
            r_flush    <= n_flush;
            r_end      <= n_end;
            r_held     <= n_held;
        end
    end

`ifndef SYNTHESIS
    a_flush_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_flush <= FLUSH_W'(FLUSH_LIMIT))
        else $error("flush counter past limit");

    a_stored_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_DATA || r_phase == PH_DATA_ESC) |-> (r_stored <= r_capacity))
        else $error("stored count past capacity");

    a_phase_legal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_phase <= PH_FL_ACK)
        else $error("phase code out of range");
`endif

endmodule

@@ rtl/dle_stuffed_frame_receiver.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// DLE stuffed frame receiver
// Unstuffs DLE/STX/ETX framed adapter bytes into payload bytes and a final
// read status.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (i_in_valid / o_in_ready / i_in_data): a transaction with
//   kind 0 arms a read of max_length bytes; kind 1 delivers one adapter byte.
//   Output channel (o_out_valid / i_out_ready / o_out_data): one transaction
//   per stored payload byte, and a last one with done_res set and the status.
//   Many input bytes (header, DLE escapes, flushed bytes) give no result.
//   Latency: a result appears in the cycle after its input is accepted.
//   Throughput: one input transaction per cycle, limited only by the
//   single-entry output register; a new input is taken in the same cycle
//   the waiting result is taken.
//   When the output side stalls with a result held, o_in_ready drops until
//   the result is taken; inputs that produce nothing still wait.
//   Configuration (i_cfg_we / i_cfg_idx / i_cfg_data) must be written by the
//   user only while idle (not enforced): index 0 eos_enable, 1 eos_char, 2
//   eos_all_bits; others ignored. Reset (i_rst_n low, synchronous) clears the
//   registers and read state to idle; bytes arriving while idle are dropped.
// ----------------------------------------------------------------------------
module dle_stuffed_frame_receiver
    import dle_rx_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_we,
    input  logic [1:0] i_cfg_idx,
    input  logic [7:0] i_cfg_data,
    input  logic       i_in_valid,
    output logic       o_in_ready,
    input  t_in_item   i_in_data,
    output logic       o_out_valid,
    input  logic       i_out_ready,
    output t_out_item  o_out_data
);

    t_cfg      r_cfg;
    logic      r_out_valid;
    t_out_item r_out_data;

    logic      step;
    logic      emit;
    t_out_item res;

    assign o_in_ready  = !r_out_valid || i_out_ready;
    assign step        = i_in_valid && o_in_ready;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_EOS_ENABLE:   r_cfg.eos_enable   <= i_cfg_data[0];
                REG_EOS_CHAR:     r_cfg.eos_char     <= i_cfg_data;
                REG_EOS_ALL_BITS: r_cfg.eos_all_bits <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    dle_rx_fsm u_fsm (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (r_cfg),
        .i_step  (step),
        .i_item  (i_in_data),
        .o_emit  (emit),
        .o_res   (res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_out_valid <= step && emit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (step && emit) begin
            r_out_data <= res;
        end
    end

`ifndef SYNTHESIS
    a_byte_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_out_data.data_valid) |-> (o_out_data.data_byte == 8'h00))
        else $error("data byte set on a status-only result");

    a_status_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_out_data.done_res) |-> (o_out_data.status == ST_OK))
        else $error("status reported before the last result");

    a_count_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_data.data_valid) |-> (o_out_data.byte_count != '0))
        else $error("payload byte with zero count");

    a_no_take_stalled: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |=> (o_out_valid && $stable(o_out_data)))
        else $error("stalled result overwritten");
`endif

endmodule
